[rtl/core/sha256_stream_hasher_macros.svh]
// assertion macros used by the sha-256 stream hasher checker
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

// same-cycle implication, off during reset
`define SHA_IMPLY(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("sha256 checker: same-cycle rule broken");

// next-cycle implication, off during reset
`define SHA_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("sha256 checker: next-cycle rule broken");

`endif

[rtl/core/sha256sh_pkg.sv]
// types, constants and round functions for the sha-256 stream hasher
`default_nettype none

package sha256sh_pkg;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD
  } state_t;

  // input commands
  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // padding constants
  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_LIMIT = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;

  // message words that carry the bit length
  localparam logic [3:0] LEN_HI_WORD = 4'd14;
  localparam logic [3:0] LEN_LO_WORD = 4'd15;

  // sequencer step limits
  localparam logic [5:0] LOAD_LAST  = 6'd16;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [5:0] FOLD_LAST  = 6'd8;

  localparam logic [2:0] LAST_INDEX = 3'd7;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // compression sigma of a
  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  // compression sigma of e
  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // schedule sigma of w[i-15]
  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  // schedule sigma of w[i-2]
  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

[rtl/core/sha256sh_if.sv]
// handshake interfaces for the message and digest channels
`default_nettype none

interface sha256sh_msg_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink (input valid, command, data_byte, output ready);
endinterface

interface sha256sh_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

[rtl/core/sha256sh_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module sha256sh_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/sha256_stream_hasher.sv]
// sha-256 stream hasher: block buffer and hash words in ram, one round per cycle
//
// msg channel: one request per message byte (command absorb) or one finish
// request that closes the message. digest channel: eight 32-bit words,
// word_index 0 to 7, last_word set on the eighth.
// Absorb requests are taken while the sequencer is idle. Every 64th byte
// starts a compression (a load that reads the 16 buffer words and the 8 hash
// words from ram, 64 rounds, and a fold that adds and writes the hash words
// back) during which msg.ready is low. A finish runs one compression, or two
// when more than 55 bytes are pending, before the first digest word; words
// then leave at one per cycle while digest.ready is high.
// Reset returns to an empty message with the initial hash values taken from
// constants; there is no ram clearing pass.
// A stalled digest holds its word. Absorb requests keep flowing meanwhile;
// a new finish waits at the start of its last write-back until the previous
// digest has fully drained.
`default_nettype none

module sha256_stream_hasher
  import sha256sh_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  sha256sh_msg_if.sink   msg,
  sha256sh_dig_if.source digest
);

  state_t       state;
  state_t       state_next;
  logic [5:0]   cnt;
  logic [5:0]   cnt_m1;
  logic [5:0]   fill;
  logic [63:0]  total;
  logic [63:0]  bits;
  logic [23:0]  stage;
  logic         fin;
  logic         blk2;
  logic         fresh;
  logic         out_busy;
  logic [2:0]   out_idx;
  logic [31:0]  w [16];
  logic [31:0]  r [8];
  logic [31:0]  dig [8];

  logic         msg_fire;
  logic         dig_fire;
  logic         len_here;
  logic         fold_go;
  logic         bram_we;
  logic [31:0]  bram_rdata;
  logic         hram_we;
  logic [31:0]  hram_rdata;
  logic [31:0]  hash_q;
  logic [31:0]  fold_sum;
  logic [31:0]  part_word;
  logic [31:0]  word_in;
  logic [31:0]  new_w;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic         load_shift;
  logic         hash_shift;
  logic         round_en;
  logic         fold_en;
  logic         block_end;

  assign msg_fire = msg.valid & msg.ready;
  assign dig_fire = out_busy & digest.ready;
  assign cnt_m1   = cnt - 6'd1;

  // this block carries the length, so it closes the message
  assign len_here = fin & (blk2 | (fill < LEN_LIMIT));
  // a closing write-back waits until the previous digest is gone
  assign fold_go  = ~(len_here & out_busy);

  // block buffer: 16 big-endian words, written when a word completes
  sha256sh_ram #(
    .WIDTH (32),
    .DEPTH (16)
  ) u_buf_ram (
    .clk   (clk),
    .we    (bram_we),
    .waddr (fill[5:2]),
    .wdata ({stage, msg.data_byte}),
    .raddr (cnt[3:0]),
    .rdata (bram_rdata)
  );

  // chaining hash words
  sha256sh_ram #(
    .WIDTH (32),
    .DEPTH (8)
  ) u_hash_ram (
    .clk   (clk),
    .we    (hram_we),
    .waddr (cnt_m1[2:0]),
    .wdata (fold_sum),
    .raddr (cnt[2:0]),
    .rdata (hram_rdata)
  );

  // hash words read back as initial values at the start of a message
  assign hash_q   = fresh ? H_INIT[cnt_m1[2:0]] : hram_rdata;
  assign fold_sum = hash_q + r[0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (msg_fire && (msg.command == CMD_FINISH || fill == FILL_LAST)) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (cnt == LOAD_LAST) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (cnt == ROUND_LAST) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (cnt == FOLD_LAST) begin
          state_next = (fin && !len_here) ? ST_LOAD : ST_IDLE;
        end
      end
    endcase
  end

  // control outputs
  always_comb begin
    msg.ready  = 1'b0;
    load_shift = 1'b0;
    hash_shift = 1'b0;
    round_en   = 1'b0;
    fold_en    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        msg.ready = 1'b1;
      end
      ST_LOAD: begin
        load_shift = (cnt != 6'd0);
        hash_shift = (cnt != 6'd0) && (cnt <= FOLD_LAST);
      end
      ST_ROUND: begin
        round_en = 1'b1;
      end
      ST_FOLD: begin
        fold_en = fold_go && (cnt != 6'd0);
      end
    endcase
  end

  assign bram_we   = msg_fire && (msg.command == CMD_ABSORB) && (fill[1:0] == 2'd3);
  assign hram_we   = fold_en;
  assign block_end = (state == ST_FOLD) && (cnt == FOLD_LAST);

  // partial word of a finish: pending bytes, then the pad byte
  always_comb begin
    case (fill[1:0])
      2'd0:    part_word = {PAD_BYTE, 24'd0};
      2'd1:    part_word = {stage[7:0], PAD_BYTE, 16'd0};
      2'd2:    part_word = {stage[15:0], PAD_BYTE, 8'd0};
      default: part_word = {stage, PAD_BYTE};
    endcase
  end

  // message word entering the schedule window
  always_comb begin
    word_in = bram_rdata;
    if (fin) begin
      word_in = 32'd0;
      if (!blk2 && cnt_m1[3:0] < fill[5:2]) begin
        word_in = bram_rdata;
      end else if (!blk2 && cnt_m1[3:0] == fill[5:2]) begin
        word_in = part_word;
      end
      if (len_here && cnt_m1[3:0] == LEN_HI_WORD) begin
        word_in = bits[63:32];
      end else if (len_here && cnt_m1[3:0] == LEN_LO_WORD) begin
        word_in = bits[31:0];
      end
    end
  end

  // one round and the next schedule word
  always_comb begin
    new_w = w[0] + small_sigma0(w[1]) + w[9] + small_sigma1(w[14]);
    t1 = r[7] + big_sigma1(r[4]) + ((r[4] & r[5]) ^ (~r[4] & r[6]))
         + ROUND_K[cnt] + w[0];
    t2 = big_sigma0(r[0]) + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
  end

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= 6'd0;
    end else begin
      state <= state_next;
      if (state != state_next) begin
        cnt <= 6'd0;
      end else if (state != ST_IDLE && !(state == ST_FOLD && !fold_go)) begin
        cnt <= cnt + 6'd1;
      end
    end
  end

  // message bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= 6'd0;
      total <= 64'd0;
      fin   <= 1'b0;
      blk2  <= 1'b0;
      fresh <= 1'b1;
    end else begin
      if (msg_fire) begin
        if (msg.command == CMD_ABSORB) begin
          fill  <= fill + 6'd1;
          total <= total + 64'd1;
        end else begin
          fin  <= 1'b1;
          blk2 <= 1'b0;
        end
      end
      if (block_end) begin
        fresh <= len_here;
        if (fin && !len_here) begin
          blk2 <= 1'b1;
        end else if (len_here) begin
          fin   <= 1'b0;
          fill  <= 6'd0;
          total <= 64'd0;
        end
      end
    end
  end

  // staging bytes and bit length
  always_ff @(posedge clk) begin
    if (msg_fire) begin
      if (msg.command == CMD_ABSORB) begin
        stage <= {stage[15:0], msg.data_byte};
      end else begin
        bits <= {total[60:0], 3'b000};
      end
    end
  end

  // schedule window
  always_ff @(posedge clk) begin
    if (load_shift || round_en) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i + 1];
      end
      w[15] <= load_shift ? word_in : new_w;
    end
  end

  // working variables a to h
  always_ff @(posedge clk) begin
    if (hash_shift || fold_en) begin
      for (int i = 0; i < 7; i++) begin
        r[i] <= r[i + 1];
      end
      r[7] <= hash_q;
    end else if (round_en) begin
      r[0] <= t1 + t2;
      r[1] <= r[0];
      r[2] <= r[1];
      r[3] <= r[2];
      r[4] <= r[3] + t1;
      r[5] <= r[4];
      r[6] <= r[5];
      r[7] <= r[6];
    end
  end

  // digest words, filled by the closing write-back and drained by the sink
  always_ff @(posedge clk) begin
    if ((fold_en && len_here) || dig_fire) begin
      for (int i = 0; i < 7; i++) begin
        dig[i] <= dig[i + 1];
      end
      dig[7] <= fold_sum;
    end
  end

  // digest channel control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_busy <= 1'b0;
      out_idx  <= 3'd0;
    end else begin
      if (dig_fire) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == LAST_INDEX) begin
          out_busy <= 1'b0;
        end
      end
      if (block_end && len_here) begin
        out_busy <= 1'b1;
        out_idx  <= 3'd0;
      end
    end
  end

  assign digest.valid       = out_busy;
  assign digest.digest_word = dig[0];
  assign digest.word_index  = out_idx;
  assign digest.last_word   = (out_idx == LAST_INDEX);

endmodule

`default_nettype wire

[rtl/core/sha256sh_chk.sv]
// port-level checker for the sha-256 stream hasher and its bind
`default_nettype none

`include "sha256_stream_hasher_macros.svh"

module sha256sh_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        dig_valid,
  input wire logic        dig_ready,
  input wire logic [31:0] dig_word,
  input wire logic [2:0]  dig_index,
  input wire logic        dig_last
);

  // words of a digest come in order
  `SHA_NEXT(a_index_step, clk, rst, dig_valid && dig_ready && !dig_last, dig_valid && (dig_index == $past(dig_index) + 3'd1))

  // a digest starts at word zero
  `SHA_IMPLY(a_first_index, clk, rst, $rose(dig_valid), dig_index == 3'd0)

  // last mark only on the eighth word
  `SHA_IMPLY(a_last_mark, clk, rst, dig_valid, dig_last == (dig_index == 3'd7))

  // the next digest never follows the last word at once
  `SHA_NEXT(a_gap_after_last, clk, rst, dig_valid && dig_ready && dig_last, !dig_valid)

  // stalled word holds
  `SHA_NEXT(a_stall_hold, clk, rst, dig_valid && !dig_ready, dig_valid && $stable(dig_word) && $stable(dig_index))

endmodule

bind sha256_stream_hasher sha256sh_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .dig_valid (digest.valid),
  .dig_ready (digest.ready),
  .dig_word  (digest.digest_word),
  .dig_index (digest.word_index),
  .dig_last  (digest.last_word)
);

`default_nettype wire
